// File: rtl/svdr_pkg.sv
// shared constants for the sine voice with decay and release
package svdr_pkg;

  // oscillator and sample format
  localparam int SAMPLE_RATE   = 48000;
  localparam int PHASE_BITS    = 32;
  localparam int SINE_IDX_BITS = 10;
  localparam int QUARTER_BITS  = SINE_IDX_BITS - 2;
  localparam int SINE_MAG_BITS = 15;
  localparam int SAMPLE_BITS   = 16;
  localparam int LEVEL_BITS    = 16;
  localparam int DECAY_BITS    = 16;

  // shared multiplier widths
  localparam int MUL_A_BITS = 32;
  localparam int MUL_B_BITS = 16;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  // sample scaling: |sine| * level * gain is Q45
  localparam int ROUND_SHIFT = 46 - SAMPLE_BITS;
  localparam int RND_BITS    = MUL_P_BITS - ROUND_SHIFT;

  // fixed-point constants
  localparam logic [DECAY_BITS-1:0] DECAY_ONE   = 16'd32768;
  localparam logic [DECAY_BITS-1:0] DECAY_MUL   = 16'd32440;
  localparam logic [DECAY_BITS-1:0] DECAY_FLOOR = 16'd1638;
  localparam logic [31:0]           HALF_PI_Q30 = 32'd1686629713;
  localparam logic [15:0]           SINE_AMP    = 16'd32767;

  // op codes carried in s_tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

endpackage

// File: rtl/sine_voice_with_decay_release.sv
// top level: one sine oscillator voice with exponential release
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tuser: op; s_tdata: note, allow_release
//  m_      | out | m_tvalid / m_tready    | m_tdata: sample_value, voice_active
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: output_level (q1.15)
//
// a tick on a sounding voice steps from accept through mul_lvl, mul_gain and decay
// to finish: three passes through the shared multiplier (sine * level, * gain, decay * 0.99)
// plus the result load; every other word goes from accept straight to finish
// the sine magnitude comes from a registered quarter-wave table read at accept
// rst (synchronous) idles the voice, zeroes phase, step, decay and level
// a full result register with m_tready low holds the sequencer in its last step
module sine_voice_with_decay_release
  import svdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] note_number, [7] allow_release
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] sample_value, [16] voice_active, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] output_level
);

  // sequencer steps
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_LVL  = 3'd1;
  localparam logic [2:0] ST_MUL_GAIN = 3'd2;
  localparam logic [2:0] ST_DECAY    = 3'd3;
  localparam logic [2:0] ST_FINISH   = 3'd4;

  localparam int NOTES = 128;

  // note frequencies 0..11 in q32 hz
  localparam logic [35:0] OCTAVE_Q32 [12] = '{
    36'd35114788961, 36'd37202822968, 36'd39415017942, 36'd41758756878,
    36'd44241861777, 36'd46872619777, 36'd49659808787, 36'd52612736802,
    36'd55741251939, 36'd59055800320, 36'd62567440939, 36'd66287894591
  };

  // sample rate scaled to the phase width, divisor of the step table
  localparam logic [63:0] STEP_DIV = 64'(SAMPLE_RATE) << (32 - PHASE_BITS);

  typedef logic [PHASE_BITS-1:0] step_tab_t [NOTES];

  // phase step = round(f * 2^phase_bits / sample_rate), wraps to phase width
  function automatic logic [PHASE_BITS-1:0] note_step_at(int n);
    logic [63:0] f;
    f = 64'(OCTAVE_Q32[n % 12]) << (n / 12);
    return PHASE_BITS'((f + (STEP_DIV >> 1)) / STEP_DIV);
  endfunction

  function automatic step_tab_t build_step_tab();
    step_tab_t t;
    for (int i = 0; i < NOTES; i++) begin
      t[i] = note_step_at(i);
    end
    return t;
  endfunction

  localparam step_tab_t NOTE_STEP = build_step_tab();

  // voice state
  logic [2:0]             state;
  logic [PHASE_BITS-1:0]  phase;
  logic [PHASE_BITS-1:0]  step;
  logic [DECAY_BITS-1:0]  decay;
  logic                   sounding;
  logic [LEVEL_BITS-1:0]  level;
  logic                   tick_run;     // current word is a tick on a sounding voice
  logic [SAMPLE_BITS-1:0] sample_q;

  // input fields
  logic [1:0] op;
  logic [6:0] note_number;
  logic       allow_release;
  logic       in_acc;
  logic       out_free;

  assign op            = s_tuser;
  assign note_number   = s_tdata[6:0];
  assign allow_release = s_tdata[7];
  assign s_tready      = (state == ST_IDLE) && !rst;
  assign in_acc        = s_tvalid && s_tready;
  assign out_free      = !m_tvalid || m_tready;
  assign cfg_ready     = !rst;

  // sine lookup follows the live phase; a sounding tick advances it, start or a hard stop zeroes it
  logic [SINE_MAG_BITS-1:0] sine_mag;
  logic                     sine_neg;

  svdr_sine_rom u_sine (
    .clk (clk),
    .idx (phase[PHASE_BITS-1 -: SINE_IDX_BITS]),
    .mag (sine_mag),
    .neg (sine_neg)
  );

  // shared multiplier operand select
  logic                  mul_en;
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [MUL_P_BITS-1:0] prod;
  logic [DECAY_BITS-1:0] gain;

  assign gain = (decay != '0) ? decay : DECAY_ONE;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      ST_MUL_LVL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_BITS'(sine_mag);
        mul_b  = level;
      end
      ST_MUL_GAIN: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_BITS'(prod[SINE_MAG_BITS+LEVEL_BITS-1:0]);
        mul_b  = gain;
      end
      ST_DECAY: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_BITS'(decay);
        mul_b  = DECAY_MUL;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  svdr_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // round half up on the magnitude, saturate, then apply the sign
  logic [RND_BITS-1:0]    rnd;
  logic [RND_BITS-1:0]    lim;
  logic [SAMPLE_BITS-1:0] sat;
  logic [SAMPLE_BITS-1:0] sample_next;

  always_comb begin
    rnd = RND_BITS'((prod + (MUL_P_BITS'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
    lim = sine_neg ? (RND_BITS'(1) << (SAMPLE_BITS - 1))
                   : ((RND_BITS'(1) << (SAMPLE_BITS - 1)) - RND_BITS'(1));
    sat = (rnd > lim) ? SAMPLE_BITS'(lim) : SAMPLE_BITS'(rnd);
    sample_next = sine_neg ? (SAMPLE_BITS'(0) - sat) : sat;
  end

  // decay step and end-of-release test, product holds decay * 0.99
  logic [DECAY_BITS-1:0] decay_next;
  logic                  release_end;
  logic                  sounding_next;

  assign decay_next    = DECAY_BITS'((prod[31:0] + 32'd16384) >> 15);
  assign release_end   = tick_run && (decay != '0) && (decay_next <= DECAY_FLOOR);
  assign sounding_next = release_end ? 1'b0 : sounding;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= '0;
      step     <= '0;
      decay    <= '0;
      sounding <= 1'b0;
      level    <= '0;
      tick_run <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        level <= cfg_data;
      end
      // finish reloads the result register itself
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            sample_q <= '0;
            // only a tick on a sounding voice needs the multiplier passes
            if ((op == OP_TICK) && sounding) begin
              tick_run <= 1'b1;
              state    <= ST_MUL_LVL;
            end else begin
              tick_run <= 1'b0;
              state    <= ST_FINISH;
            end
            case (op)
              OP_START: begin
                phase    <= '0;
                step     <= NOTE_STEP[note_number];
                decay    <= '0;
                sounding <= 1'b1;
              end
              OP_STOP: begin
                if (allow_release) begin
                  // release starts only once; a spent release keeps its factor
                  if (sounding && (decay == '0)) begin
                    decay <= DECAY_ONE;
                  end
                end else begin
                  sounding <= 1'b0;
                  phase    <= '0;
                end
              end
              default: begin
                // tick and unused op code: no state change here
              end
            endcase
          end
        end
        ST_MUL_LVL: begin
          state <= ST_MUL_GAIN;
        end
        ST_MUL_GAIN: begin
          state <= ST_DECAY;
        end
        ST_DECAY: begin
          sample_q <= sample_next;
          phase    <= phase + step;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            if (tick_run && (decay != '0)) begin
              decay <= decay_next;
            end
            if (release_end) begin
              sounding <= 1'b0;
              step     <= '0;
            end
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, sounding_next, sample_q};
            tick_run <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a tick on a sounding voice always goes through the multiplier passes
  a_tick_runs: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_TICK) && sounding |=> (state == ST_MUL_LVL) && tick_run)
    else $error("tick on sounding voice skipped the multiply sequence");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) && m_tvalid && !m_tready |=> (state == ST_FINISH))
    else $error("sequencer left finish while result register was full");

  // decay moves only on an accepted word or at the end of a tick
  a_decay_stable: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) && !in_acc |=> $stable(decay))
    else $error("decay factor changed outside accept or finish");

  // the voice falls silent only through a stop, release end or reset
  a_silence_src: assert property (@(posedge clk) disable iff (rst)
    $fell(sounding) |-> $past(rst) || $past(state == ST_FINISH) || $past(in_acc))
    else $error("voice went idle without a cause");

endmodule

// File: rtl/svdr_sine_rom.sv
// quarter-wave sine lookup with registered magnitude and sign
module svdr_sine_rom
  import svdr_pkg::*;
(
  input  logic                     clk,
  input  logic [SINE_IDX_BITS-1:0] idx,
  output logic [SINE_MAG_BITS-1:0] mag,
  output logic                     neg
);

  localparam int QUARTER = 1 << QUARTER_BITS;

  typedef logic [SINE_MAG_BITS-1:0] sine_tab_t [QUARTER];

  // taylor series to x^11 in q30, products truncated, scaled to 0..32767
  function automatic logic [SINE_MAG_BITS-1:0] sine_at(int k);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    r    = 64'(k) << (30 - QUARTER_BITS);
    x    = (r * 64'(HALF_PI_Q30)) >> 30;
    term = x;
    sum  = longint'(x);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd6;
    sum  = sum - longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd20;
    sum  = sum + longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd42;
    sum  = sum - longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd72;
    sum  = sum + longint'(term);
    term = (term * x) >> 30;
    term = (term * x) >> 30;
    term = term / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return SINE_MAG_BITS'(((64'(sum) * 64'(SINE_AMP)) + 64'h2000_0000) >> 30);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = sine_at(i);
    end
    return t;
  endfunction

  localparam sine_tab_t                SINE_TAB  = build_sine_tab();
  localparam logic [SINE_MAG_BITS-1:0] SINE_PEAK = sine_at(QUARTER);

  logic [1:0]              quad;
  logic [QUARTER_BITS-1:0] low;

  assign quad = idx[SINE_IDX_BITS-1 -: 2];
  assign low  = idx[QUARTER_BITS-1:0];

  // odd quadrants run the quarter wave backwards; the top of it is the peak
  always_ff @(posedge clk) begin
    if (quad[0]) begin
      if (low == '0) begin
        mag <= SINE_PEAK;
      end else begin
        mag <= SINE_TAB[QUARTER_BITS'(0) - low];
      end
    end else begin
      mag <= SINE_TAB[low];
    end
    neg <= quad[1];
  end

endmodule

// File: rtl/svdr_mul.sv
// shared 32 x 16 unsigned multiplier with registered product
module svdr_mul
  import svdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [MUL_A_BITS-1:0] a,
  input  logic [MUL_B_BITS-1:0] b,
  output logic [MUL_P_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
    end
  end

endmodule
